>>> rtl/core/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked at each rising edge outside reset
`define SPVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication, checked at each rising edge outside reset
`define SPVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SPVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/spvp_pkg.sv
// shared types, constants and tables for the pulse vector potential block
package spvp_pkg;

    localparam int INDEX_BITS_DEF    = 20;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam int CFG_DATA_W        = 48;
    localparam int CFG_INDEX_W       = 3;
    localparam int ROT_W             = 34;
    localparam int FACTOR_STEPS      = 32;

    localparam logic signed [ROT_W-1:0] GAIN_INV_Q30 = 34'sd652032874;

    // arctangent of 2^-i in 32-bit fractions of a turn
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PEAK     = 3'd0,
        CFG_CARRIER  = 3'd1,
        CFG_CYCLES   = 3'd2,
        CFG_OFFSET   = 3'd3,
        CFG_ELL      = 3'd4,
        CFG_POL_VEC  = 3'd5,
        CFG_ELL_VEC  = 3'd6
    } t_cfg_reg;

    // component codes
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // one rotator state with its quadrant
    typedef struct packed {
        logic [1:0]              quad;
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } t_rot;

    // what travels along the cordic chain
    typedef struct packed {
        logic               valid;
        t_rot               car;
        t_rot               env;
        logic [1:0]         comp;
        logic signed [15:0] pol;
        logic signed [15:0] ev;
    } t_cell_bus;

    // derived factor status
    typedef struct packed {
        logic        busy;
        logic [15:0] norm;
        logic [31:0] env_step;
    } t_factors;

    typedef struct packed {
        logic signed [ROT_W-1:0] s;
        logic signed [ROT_W-1:0] c;
    } t_sc;

    // fold quadrant back onto the rotated vector
    function automatic t_sc quad_map(input t_rot r);
        t_sc v;
        case (r.quad)
            2'd0: begin
                v.c = r.x;
                v.s = r.y;
            end
            2'd1: begin
                v.c = -r.y;
                v.s = r.x;
            end
            2'd2: begin
                v.c = -r.x;
                v.s = -r.y;
            end
            default: begin
                v.c = r.y;
                v.s = -r.x;
            end
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/sin2_pulse_vector_potential_top.sv
// top level: sin^2 envelope elliptical pulse vector potential, one component per item
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+----------------------------------
//  input     | i_in_valid / o_in_ready       | i_sample_index, i_component
//  output    | o_out_valid / i_out_ready     | o_potential, o_component_out
//  config    | i_cfg_we                      | i_cfg_index, i_cfg_data
//
// one item per cycle while the output is free or taken and the factor unit is idle
// after reset and each config write to index 0 to 6 the factor unit runs, o_in_ready low
// a result held in the output register that is not taken freezes the whole chain
// reset is synchronous and clears config to defaults and all valid bits
module sin2_pulse_vector_potential_top #(
    parameter int INDEX_BITS    = spvp_pkg::INDEX_BITS_DEF,
    parameter int CORDIC_STAGES = spvp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spvp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [spvp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [INDEX_BITS-1:0]             i_sample_index,
    input  logic [1:0]                        i_component,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [17:0]                o_potential,
    output logic [1:0]                        o_component_out
);

    // configuration registers
    logic [14:0]        r_peak;
    logic [31:0]        r_carrier_step;
    logic [10:0]        r_cycle_count;
    logic [31:0]        r_phase_offset;
    logic signed [15:0] r_ell;
    logic [47:0]        r_pol_vec;
    logic [47:0]        r_ell_vec;

    logic               w_start;
    spvp_pkg::t_factors w_fac;
    logic               w_en;
    logic               w_accept;

    assign w_start = i_cfg_we && (i_cfg_index <= spvp_pkg::CFG_ELL_VEC);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak         <= 15'd16384;
            r_carrier_step <= '0;
            r_cycle_count  <= 11'd1;
            r_phase_offset <= '0;
            r_ell          <= '0;
            r_pol_vec      <= 48'd16384;
            r_ell_vec      <= '0;
        end else if (i_cfg_we) begin
            case (spvp_pkg::t_cfg_reg'(i_cfg_index))
                spvp_pkg::CFG_PEAK:    r_peak         <= i_cfg_data[14:0];
                spvp_pkg::CFG_CARRIER: r_carrier_step <= i_cfg_data[31:0];
                spvp_pkg::CFG_CYCLES:  r_cycle_count  <= i_cfg_data[10:0];
                spvp_pkg::CFG_OFFSET:  r_phase_offset <= i_cfg_data[31:0];
                spvp_pkg::CFG_ELL:     r_ell          <= i_cfg_data[15:0];
                spvp_pkg::CFG_POL_VEC: r_pol_vec      <= i_cfg_data;
                spvp_pkg::CFG_ELL_VEC: r_ell_vec      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spvp_factor u_factor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_carrier_step (r_carrier_step),
        .i_cycle_count  (r_cycle_count),
        .i_ell          (r_ell),
        .o_factors      (w_fac)
    );

    // global advance: output register free or being taken
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en && !w_fac.busy;
    assign w_accept   = i_in_valid && o_in_ready;

    // stage p0: phase products and component select
    logic               r_p0_v;
    logic [31:0]        r_p0_pc;
    logic [31:0]        r_p0_pe;
    logic [1:0]         r_p0_comp;
    logic signed [15:0] r_p0_pol;
    logic signed [15:0] r_p0_ev;
    logic [63:0]        w_n64;
    logic [63:0]        w_pc_prod;
    logic [63:0]        w_pe_prod;
    logic [15:0]        w_pol_sel;
    logic [15:0]        w_ev_sel;

    assign w_n64     = 64'(i_sample_index);
    assign w_pc_prod = {32'd0, r_carrier_step} * w_n64;
    assign w_pe_prod = {32'd0, w_fac.env_step} * w_n64;

    always_comb begin
        case (i_component)
            spvp_pkg::COMP_X: begin
                w_pol_sel = r_pol_vec[15:0];
                w_ev_sel  = r_ell_vec[15:0];
            end
            spvp_pkg::COMP_Y: begin
                w_pol_sel = r_pol_vec[31:16];
                w_ev_sel  = r_ell_vec[31:16];
            end
            spvp_pkg::COMP_Z: begin
                w_pol_sel = r_pol_vec[47:32];
                w_ev_sel  = r_ell_vec[47:32];
            end
            default: begin
                w_pol_sel = '0;
                w_ev_sel  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v <= 1'b0;
        end else if (w_en) begin
            r_p0_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_pc   <= w_pc_prod[31:0];
            r_p0_pe   <= w_pe_prod[31:0];
            r_p0_comp <= i_component;
            r_p0_pol  <= w_pol_sel;
            r_p0_ev   <= w_ev_sel;
        end
    end

    // stage p1: carrier phase offset and rotator setup
    spvp_pkg::t_cell_bus r_p1;
    spvp_pkg::t_cell_bus n_p1;
    logic                w_odd;
    logic [31:0]         w_pc;

    assign w_odd = (r_cycle_count == 11'd0) || r_cycle_count[0];
    assign w_pc  = r_p0_pc + r_phase_offset + {w_odd, 31'd0};

    always_comb begin
        n_p1.valid    = r_p0_v;
        n_p1.car.quad = w_pc[31:30];
        n_p1.car.x    = spvp_pkg::GAIN_INV_Q30;
        n_p1.car.y    = '0;
        n_p1.car.z    = spvp_pkg::ROT_W'(w_pc[29:0]);
        n_p1.env.quad = r_p0_pe[31:30];
        n_p1.env.x    = spvp_pkg::GAIN_INV_Q30;
        n_p1.env.y    = '0;
        n_p1.env.z    = spvp_pkg::ROT_W'(r_p0_pe[29:0]);
        n_p1.comp     = r_p0_comp;
        n_p1.pol      = r_p0_pol;
        n_p1.ev       = r_p0_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.valid <= 1'b0;
        end else if (w_en) begin
            r_p1 <= n_p1;
        end
    end

    // cordic cell chain
    spvp_pkg::t_cell_bus w_chain [CORDIC_STAGES+1];

    assign w_chain[0] = r_p1;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        spvp_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bus   (w_chain[g]),
            .o_bus   (w_chain[g+1])
        );
    end

    // stage a: squares and first products
    spvp_pkg::t_cell_bus w_last;
    spvp_pkg::t_sc       w_sc_c;
    spvp_pkg::t_sc       w_sc_e;
    logic signed [31:0]  w_se;
    logic signed [31:0]  w_s;
    logic signed [31:0]  w_c;
    logic                r_a_v;
    logic [1:0]          r_a_comp;
    logic signed [63:0]  r_a_se2;
    logic signed [47:0]  r_a_pols;
    logic signed [31:0]  r_a_ellev;
    logic signed [31:0]  r_a_c;
    logic [30:0]         r_a_pn;

    assign w_last = w_chain[CORDIC_STAGES];
    assign w_sc_c = spvp_pkg::quad_map(w_last.car);
    assign w_sc_e = spvp_pkg::quad_map(w_last.env);
    assign w_se   = w_sc_e.s[31:0];
    assign w_s    = w_sc_c.s[31:0];
    assign w_c    = w_sc_c.c[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_comp  <= w_last.comp;
            r_a_se2   <= w_se * w_se;
            r_a_pols  <= w_last.pol * w_s;
            r_a_ellev <= r_ell * w_last.ev;
            r_a_c     <= w_c;
            r_a_pn    <= r_peak * w_fac.norm;
        end
    end

    // stage b: envelope amplitude and ellipse term products
    logic signed [63:0] w_sq_full;
    logic signed [31:0] w_sq;
    logic signed [31:0] w_pn_s;
    logic               r_b_v;
    logic [1:0]         r_b_comp;
    logic signed [63:0] r_b_amp_raw;
    logic signed [63:0] r_b_t;
    logic signed [47:0] r_b_pols;

    assign w_sq_full = r_a_se2 >>> 30;
    assign w_sq      = w_sq_full[31:0];
    assign w_pn_s    = $signed({1'b0, r_a_pn});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_comp    <= r_a_comp;
            r_b_amp_raw <= w_pn_s * w_sq;
            r_b_t       <= r_a_ellev * r_a_c;
            r_b_pols    <= r_a_pols;
        end
    end

    // stage c: bracket reduction and amplitude scaling
    logic signed [63:0] w_pols64;
    logic signed [63:0] w_inner_sum;
    logic signed [63:0] w_inner_full;
    logic signed [63:0] w_amp_full;
    logic               r_c_v;
    logic [1:0]         r_c_comp;
    logic signed [32:0] r_c_amp;
    logic signed [19:0] r_c_inner;

    assign w_pols64     = r_b_pols;
    assign w_inner_sum  = w_pols64 + (r_b_t >>> 14);
    assign w_inner_full = w_inner_sum >>> 29;
    assign w_amp_full   = r_b_amp_raw >>> 30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_comp  <= r_b_comp;
            r_c_amp   <= w_amp_full[32:0];
            r_c_inner <= w_inner_full[19:0];
        end
    end

    // stage d: final product, saturation, output register
    logic signed [52:0] w_res_prod;
    logic signed [52:0] w_res_full;
    logic signed [23:0] w_res;
    logic signed [17:0] w_sat;
    logic               r_out_v;
    logic signed [17:0] r_out_pot;
    logic [1:0]         r_out_comp;

    assign w_res_prod = r_c_amp * r_c_inner;
    assign w_res_full = w_res_prod >>> 29;
    assign w_res      = w_res_full[23:0];

    always_comb begin
        if (r_c_comp == 2'd3) begin
            w_sat = '0;
        end else if (w_res > 24'sd131071) begin
            w_sat = 18'sd131071;
        end else if (w_res < -24'sd131072) begin
            w_sat = -18'sd131072;
        end else begin
            w_sat = w_res[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pot  <= w_sat;
            r_out_comp <= r_c_comp;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_potential     = r_out_pot;
    assign o_component_out = r_out_comp;

    // checks
    `include "assert_macros.svh"

    `SPVP_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, w_accept, !w_fac.busy)
    `SPVP_ASSERT_NXT(a_cfg_starts_factor, i_clk, i_rst_n, w_start, w_fac.busy && !o_in_ready)
    `SPVP_ASSERT_IMP(a_comp3_zero, i_clk, i_rst_n, r_out_v && (r_out_comp == 2'd3), r_out_pot == 18'sd0)

endmodule

>>> rtl/core/spvp_factor.sv
// iterative unit for norm factor (bit search sqrt) and envelope step (division)
module spvp_factor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_carrier_step,
    input  logic [10:0]         i_cycle_count,
    input  logic signed [15:0]  i_ell,
    output spvp_pkg::t_factors  o_factors
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [11:0] r_rem;
    logic [31:0] r_quot;
    logic [15:0] r_q;
    logic [31:0] r_sq;
    logic [30:0] r_s;

    logic [10:0] w_eff_n;
    logic [11:0] w_div;
    logic [12:0] w_rem_sh;
    logic        w_ge;
    logic [3:0]  w_bit;
    logic [15:0] w_cand;
    logic signed [31:0] w_ell_sq;
    logic [62:0] w_prod;

    // restoring division step, one quotient bit per cycle
    assign w_eff_n  = (i_cycle_count == 11'd0) ? 11'd1 : i_cycle_count;
    assign w_div    = {w_eff_n, 1'b0};
    assign w_rem_sh = {r_rem, i_carrier_step[~r_cnt]};
    assign w_ge     = (w_rem_sh >= {1'b0, w_div});

    // square root bit search, operands registered on even counts, compared on odd ones
    assign w_bit    = ~r_cnt[4:1];
    assign w_cand   = r_q | (16'd1 << w_bit);
    assign w_ell_sq = i_ell * i_ell;
    assign w_prod   = r_sq * r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quot <= '0;
            r_q    <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 5'd1;
            r_busy <= (r_cnt != 5'd31);
            r_rem  <= w_ge ? 12'(w_rem_sh - {1'b0, w_div}) : w_rem_sh[11:0];
            r_quot <= {r_quot[30:0], w_ge};
            if (r_cnt[0] && (w_prod <= (63'd1 << 58))) begin
                r_q <= w_cand;
            end
        end
    end

    // operand registers for the sqrt compare
    always_ff @(posedge i_clk) begin
        if (!r_cnt[0]) begin
            r_sq <= w_cand * w_cand;
            r_s  <= (31'd1 << 28) + 31'(w_ell_sq);
        end
    end

    assign o_factors.busy     = r_busy;
    assign o_factors.norm     = r_q;
    assign o_factors.env_step = r_quot;

endmodule

>>> rtl/core/spvp_cordic_cell.sv
// one cordic micro-rotation cell for the carrier and envelope rotators
module spvp_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  spvp_pkg::t_cell_bus  i_bus,
    output spvp_pkg::t_cell_bus  o_bus
);

    localparam logic signed [spvp_pkg::ROT_W-1:0] ATAN =
        spvp_pkg::ROT_W'(spvp_pkg::ATAN_TURNS[STAGE]);

    spvp_pkg::t_cell_bus r_bus;
    spvp_pkg::t_cell_bus n_bus;

    function automatic spvp_pkg::t_rot rotate(input spvp_pkg::t_rot r);
        spvp_pkg::t_rot o;
        o = r;
        if (r.z >= 0) begin
            o.x = r.x - (r.y >>> STAGE);
            o.y = r.y + (r.x >>> STAGE);
            o.z = r.z - ATAN;
        end else begin
            o.x = r.x + (r.y >>> STAGE);
            o.y = r.y - (r.x >>> STAGE);
            o.z = r.z + ATAN;
        end
        return o;
    endfunction

    // rotate both vectors, pass side data along
    always_comb begin
        n_bus     = i_bus;
        n_bus.car = rotate(i_bus.car);
        n_bus.env = rotate(i_bus.env);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule
